// File: rtl/first_fit_region_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the first-fit region allocator
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_REGION_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication
`define FFRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Types, codes and sizes shared by the region allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ffra_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned PAGE_BITS   = 12;
  localparam int unsigned MAX_REGIONS = 64;
  localparam int unsigned BASE_W      = ADDR_W - PAGE_BITS;
  localparam int unsigned SIZE_W      = BASE_W + 1;
  localparam int unsigned BYTES_W     = ADDR_W + 1;
  localparam int unsigned IDX_W       = $clog2(MAX_REGIONS);
  localparam int unsigned CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned STAT_W      = 3;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned CFG_AW      = 4;
  localparam int unsigned CFG_DW      = 64;
  localparam int unsigned SPAN_PAGES  = 1 << BASE_W;

  localparam logic [CMD_W-1:0] CMD_INIT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FIXED  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FREE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_MERGE  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_FIT    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_CMD   = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] size_bytes;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [ADDR_W-1:0]      region_base;
    logic [BYTES_W-1:0]     region_size;
    logic                   region_is_free;
    logic [COUNT_OUT_W-1:0] region_count;
  } out_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ADDR_W-1:0]  base;
    logic [BYTES_W-1:0] size;
    logic               free;
  } res_t;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic              free;
  } entry_t;

  typedef enum logic [3:0] {
    S_BOOT, S_IDLE, S_DISP, S_RD, S_CHK, S_DECIDE, S_SH_RD, S_SH_WR,
    S_WR_L, S_WR_M, S_WR_R, S_MFIN, S_DONE
  } state_e;

  typedef enum logic [1:0] {IDX_HOLD, IDX_INC, IDX_DEC, IDX_TOP} idx_op_e;

  typedef enum logic [2:0] {
    WR_NONE, WR_SHIFT, WR_LEFT, WR_MID, WR_RIGHT, WR_FREE, WR_MACC
  } wr_e;

  typedef enum logic [1:0] {CNT_HOLD, CNT_ADD_NEED, CNT_MERGE} cnt_op_e;

  typedef enum logic [2:0] {RES_KEEP, RES_ZERO, RES_ENT, RES_FREED, RES_ALLOC} res_op_e;

  typedef struct packed {
    logic              load;
    logic              init;
    logic              rd;
    idx_op_e           idx_op;
    logic              hit;
    logic              merge_step;
    wr_e               wr;
    cnt_op_e           cnt_op;
    res_op_e           res;
    logic [STAT_W-1:0] status;
    logic              publish;
  } dp_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] req_cmd;
    logic             count_zero;
    logic             last;
    logic             match;
    logic             bad_size;
    logic             hit_free;
    logic             fit_fail;
    logic             full;
    logic             need_zero;
    logic             has_off;
    logic             has_rem;
    logic             shift_any;
    logic             shift_more;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// Region table memory, working registers and compare/split arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ffra_pkg::dp_cmd_t               cmd_i,
  output ffra_pkg::dp_stat_t              stat_o,
  input  ffra_pkg::in_t                   in_data_i,
  input  logic [ffra_pkg::ADDR_W-1:0]     space_base_i,
  input  logic [ffra_pkg::BYTES_W-1:0]    space_size_i,
  output ffra_pkg::out_t                  out_data_o
);

  localparam int unsigned AW = ffra_pkg::ADDR_W;
  localparam int unsigned PB = ffra_pkg::PAGE_BITS;
  localparam int unsigned BW = ffra_pkg::BASE_W;
  localparam int unsigned SW = ffra_pkg::SIZE_W;
  localparam int unsigned IW = ffra_pkg::IDX_W;
  localparam int unsigned CW = ffra_pkg::CNT_W;

  ffra_pkg::entry_t mem [ffra_pkg::MAX_REGIONS];
  ffra_pkg::entry_t rd_q, ent_q;

  logic [ffra_pkg::CMD_W-1:0] cmd_q;
  logic [AW-1:0]              addr_q;
  logic [SW-1:0]              pages_q, off_q;
  logic                       bad_q;
  logic [CW-1:0]              count_q;
  logic [IW-1:0]              idx_q, wi_q, hit_q;
  ffra_pkg::res_t             res_q;
  ffra_pkg::out_t             out_q;

  logic [AW:0]      round_sum;
  logic [BW-1:0]    ap, init_bp, mid_base, right_base;
  logic [SW-1:0]    init_sp, init_avail, init_pages, e_end, avail, rem;
  logic             contains, match, has_off, has_rem, full, first, join_free;
  logic [1:0]       need;
  logic [CW-1:0]    hit_p1;
  logic [IW-1:0]    mid_idx;
  logic             we;
  logic [IW-1:0]    wa;
  ffra_pkg::entry_t wd;

  assign round_sum  = {1'b0, in_data_i.size_bytes} + (AW+1)'((1 << PB) - 1);

  assign init_bp    = space_base_i[AW-1:PB];
  assign init_sp    = space_size_i[AW:PB];
  assign init_avail = SW'(ffra_pkg::SPAN_PAGES) - {1'b0, init_bp};
  assign init_pages = (init_sp < init_avail) ? init_sp : init_avail;

  assign ap       = addr_q[AW-1:PB];
  assign e_end    = {1'b0, rd_q.base} + rd_q.size;
  assign contains = (ap >= rd_q.base) && ({1'b0, ap} < e_end);

  always_comb begin
    case (cmd_q)
      ffra_pkg::CMD_LOOKUP, ffra_pkg::CMD_FIXED: match = contains;
      ffra_pkg::CMD_ALLOC: match = rd_q.free && (rd_q.size >= pages_q);
      ffra_pkg::CMD_FREE:  match = !(|addr_q[PB-1:0]) && (ap == rd_q.base);
      default:             match = 1'b0;
    endcase
  end

  assign avail      = ent_q.size - off_q;
  assign rem        = avail - pages_q;
  assign has_off    = (off_q != '0);
  assign has_rem    = (rem != '0);
  assign need       = {1'b0, has_off} + {1'b0, has_rem};
  assign full       = ({1'b0, count_q} + (CW+1)'(need)) > (CW+1)'(ffra_pkg::MAX_REGIONS);
  assign mid_base   = ent_q.base + off_q[BW-1:0];
  assign right_base = mid_base + pages_q[BW-1:0];
  assign mid_idx    = hit_q + IW'(has_off);
  assign hit_p1     = CW'(hit_q) + CW'(1);
  assign first      = (idx_q == '0);
  assign join_free  = ent_q.free && rd_q.free;

  always_comb begin
    stat_o.req_cmd    = cmd_q;
    stat_o.count_zero = (count_q == '0);
    stat_o.last       = (CW'(idx_q) + CW'(1)) == count_q;
    stat_o.match      = match;
    stat_o.bad_size   = bad_q;
    stat_o.hit_free   = ent_q.free;
    stat_o.fit_fail   = !ent_q.free || (avail < pages_q);
    stat_o.full       = full;
    stat_o.need_zero  = (need == 2'd0);
    stat_o.has_off    = has_off;
    stat_o.has_rem    = has_rem;
    stat_o.shift_any  = count_q > hit_p1;
    stat_o.shift_more = CW'(idx_q) > hit_p1;
  end

  always_comb begin
    we = 1'b1;
    wa = '0;
    wd = ent_q;
    case (cmd_i.wr)
      ffra_pkg::WR_SHIFT: begin
        wa = idx_q + IW'(need);
        wd = rd_q;
      end
      ffra_pkg::WR_LEFT: begin
        wa = hit_q;
        wd = '{base: ent_q.base, size: off_q, free: 1'b1};
      end
      ffra_pkg::WR_MID: begin
        wa = mid_idx;
        wd = '{base: mid_base, size: pages_q, free: 1'b0};
      end
      ffra_pkg::WR_RIGHT: begin
        wa = mid_idx + IW'(1);
        wd = '{base: right_base, size: rem, free: 1'b1};
      end
      ffra_pkg::WR_FREE: begin
        wa = hit_q;
        wd = '{base: ent_q.base, size: ent_q.size, free: 1'b1};
      end
      ffra_pkg::WR_MACC: begin
        wa = wi_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
    if (cmd_i.init) begin
      we = (init_pages != '0);
      wa = '0;
      wd = '{base: init_bp, size: init_pages, free: 1'b1};
    end
    if (cmd_i.merge_step && !first && !join_free) begin
      we = 1'b1;
      wa = wi_q;
      wd = ent_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      wi_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        idx_q <= '0;
        wi_q  <= '0;
      end else begin
        case (cmd_i.idx_op)
          ffra_pkg::IDX_INC: idx_q <= idx_q + IW'(1);
          ffra_pkg::IDX_DEC: idx_q <= idx_q - IW'(1);
          ffra_pkg::IDX_TOP: idx_q <= IW'(count_q - CW'(1));
          default:           idx_q <= idx_q;
        endcase
      end
      if (cmd_i.merge_step && !first && !join_free) begin
        wi_q <= wi_q + IW'(1);
      end
      if (cmd_i.init) begin
        count_q <= (init_pages != '0) ? CW'(1) : '0;
      end else begin
        case (cmd_i.cnt_op)
          ffra_pkg::CNT_ADD_NEED: count_q <= count_q + CW'(need);
          ffra_pkg::CNT_MERGE:    count_q <= CW'(wi_q) + CW'(1);
          default:                count_q <= count_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q   <= in_data_i.cmd;
      addr_q  <= in_data_i.address;
      pages_q <= SW'(round_sum[AW-1:PB]);
      bad_q   <= (in_data_i.size_bytes == '0) || round_sum[AW] ||
                 ((in_data_i.cmd == ffra_pkg::CMD_FIXED) && (|in_data_i.address[PB-1:0]));
    end
    if (cmd_i.hit) begin
      ent_q <= rd_q;
      hit_q <= idx_q;
      off_q <= (cmd_q == ffra_pkg::CMD_FIXED) ? SW'(ap - rd_q.base) : '0;
    end
    if (cmd_i.merge_step) begin
      if (!first && join_free) begin
        ent_q.size <= ent_q.size + rd_q.size;
      end else begin
        ent_q <= rd_q;
      end
    end
    if (cmd_i.init) begin
      res_q.status <= ffra_pkg::ST_OK;
      res_q.base   <= (init_pages != '0) ? {init_bp, PB'(0)} : '0;
      res_q.size   <= {init_pages, PB'(0)};
      res_q.free   <= (init_pages != '0);
    end else begin
      case (cmd_i.res)
        ffra_pkg::RES_ZERO: res_q <= '{status: cmd_i.status, default: '0};
        ffra_pkg::RES_ENT:
          res_q <= '{status: ffra_pkg::ST_OK, base: {ent_q.base, PB'(0)},
                     size: {ent_q.size, PB'(0)}, free: ent_q.free};
        ffra_pkg::RES_FREED:
          res_q <= '{status: ffra_pkg::ST_OK, base: {ent_q.base, PB'(0)},
                     size: {ent_q.size, PB'(0)}, free: 1'b1};
        ffra_pkg::RES_ALLOC:
          res_q <= '{status: ffra_pkg::ST_OK, base: {mid_base, PB'(0)},
                     size: {pages_q, PB'(0)}, free: 1'b0};
        default: res_q <= res_q;
      endcase
    end
    if (cmd_i.publish) begin
      out_q <= '{status: res_q.status, region_base: res_q.base, region_size: res_q.size,
                 region_is_free: res_q.free,
                 region_count: ffra_pkg::COUNT_OUT_W'(count_q)};
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// File: rtl/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Command sequencer: scan, shift, split-write, merge and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module ffra_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  ffra_pkg::dp_stat_t stat_i,
  output ffra_pkg::dp_cmd_t  cmd_o
);

  ffra_pkg::state_e  state_q, state_d;
  logic              out_valid_q, out_valid_d;
  ffra_pkg::dp_cmd_t c;
  logic [ffra_pkg::STAT_W-1:0] miss_st;

  assign miss_st = (stat_i.req_cmd == ffra_pkg::CMD_ALLOC) ? ffra_pkg::ST_NO_FIT
                                                           : ffra_pkg::ST_NOT_FOUND;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffra_pkg::S_BOOT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    c          = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      ffra_pkg::S_BOOT: begin
        c.init  = 1'b1;
        state_d = ffra_pkg::S_IDLE;
      end
      ffra_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          c.load  = 1'b1;
          state_d = ffra_pkg::S_DISP;
        end
      end
      ffra_pkg::S_DISP: begin
        state_d = ffra_pkg::S_DONE;
        case (stat_i.req_cmd)
          ffra_pkg::CMD_INIT: c.init = 1'b1;
          ffra_pkg::CMD_LOOKUP, ffra_pkg::CMD_FREE: begin
            if (stat_i.count_zero) begin
              c.res    = ffra_pkg::RES_ZERO;
              c.status = ffra_pkg::ST_NOT_FOUND;
            end else begin
              state_d = ffra_pkg::S_RD;
            end
          end
          ffra_pkg::CMD_ALLOC, ffra_pkg::CMD_FIXED: begin
            if (stat_i.bad_size) begin
              c.res    = ffra_pkg::RES_ZERO;
              c.status = ffra_pkg::ST_BAD_SIZE;
            end else if (stat_i.count_zero) begin
              c.res    = ffra_pkg::RES_ZERO;
              c.status = miss_st;
            end else begin
              state_d = ffra_pkg::S_RD;
            end
          end
          ffra_pkg::CMD_MERGE: begin
            if (stat_i.count_zero) begin
              c.res    = ffra_pkg::RES_ZERO;
              c.status = ffra_pkg::ST_OK;
            end else begin
              state_d = ffra_pkg::S_RD;
            end
          end
          default: begin
            c.res    = ffra_pkg::RES_ZERO;
            c.status = ffra_pkg::ST_BAD_CMD;
          end
        endcase
      end
      ffra_pkg::S_RD: begin
        c.rd    = 1'b1;
        state_d = ffra_pkg::S_CHK;
      end
      ffra_pkg::S_CHK: begin
        if (stat_i.req_cmd == ffra_pkg::CMD_MERGE) begin
          c.merge_step = 1'b1;
          if (stat_i.last) begin
            state_d = ffra_pkg::S_MFIN;
          end else begin
            c.idx_op = ffra_pkg::IDX_INC;
            state_d  = ffra_pkg::S_RD;
          end
        end else if (stat_i.match) begin
          c.hit   = 1'b1;
          state_d = ffra_pkg::S_DECIDE;
        end else if (stat_i.last) begin
          c.res    = ffra_pkg::RES_ZERO;
          c.status = miss_st;
          state_d  = ffra_pkg::S_DONE;
        end else begin
          c.idx_op = ffra_pkg::IDX_INC;
          state_d  = ffra_pkg::S_RD;
        end
      end
      ffra_pkg::S_DECIDE: begin
        state_d = ffra_pkg::S_DONE;
        case (stat_i.req_cmd)
          ffra_pkg::CMD_LOOKUP: c.res = ffra_pkg::RES_ENT;
          ffra_pkg::CMD_FREE: begin
            if (stat_i.hit_free) begin
              c.res    = ffra_pkg::RES_ZERO;
              c.status = ffra_pkg::ST_NO_FIT;
            end else begin
              c.wr  = ffra_pkg::WR_FREE;
              c.res = ffra_pkg::RES_FREED;
            end
          end
          default: begin
            if (stat_i.fit_fail) begin
              c.res    = ffra_pkg::RES_ZERO;
              c.status = ffra_pkg::ST_NO_FIT;
            end else if (stat_i.full) begin
              c.res    = ffra_pkg::RES_ZERO;
              c.status = ffra_pkg::ST_FULL;
            end else if (stat_i.need_zero) begin
              state_d = ffra_pkg::S_WR_M;
            end else if (stat_i.shift_any) begin
              c.idx_op = ffra_pkg::IDX_TOP;
              state_d  = ffra_pkg::S_SH_RD;
            end else begin
              state_d = stat_i.has_off ? ffra_pkg::S_WR_L : ffra_pkg::S_WR_M;
            end
          end
        endcase
      end
      ffra_pkg::S_SH_RD: begin
        c.rd    = 1'b1;
        state_d = ffra_pkg::S_SH_WR;
      end
      ffra_pkg::S_SH_WR: begin
        c.wr = ffra_pkg::WR_SHIFT;
        if (stat_i.shift_more) begin
          c.idx_op = ffra_pkg::IDX_DEC;
          state_d  = ffra_pkg::S_SH_RD;
        end else begin
          state_d = stat_i.has_off ? ffra_pkg::S_WR_L : ffra_pkg::S_WR_M;
        end
      end
      ffra_pkg::S_WR_L: begin
        c.wr    = ffra_pkg::WR_LEFT;
        state_d = ffra_pkg::S_WR_M;
      end
      ffra_pkg::S_WR_M: begin
        c.wr     = ffra_pkg::WR_MID;
        c.res    = ffra_pkg::RES_ALLOC;
        c.cnt_op = ffra_pkg::CNT_ADD_NEED;
        state_d  = stat_i.has_rem ? ffra_pkg::S_WR_R : ffra_pkg::S_DONE;
      end
      ffra_pkg::S_WR_R: begin
        c.wr    = ffra_pkg::WR_RIGHT;
        state_d = ffra_pkg::S_DONE;
      end
      ffra_pkg::S_MFIN: begin
        c.wr     = ffra_pkg::WR_MACC;
        c.cnt_op = ffra_pkg::CNT_MERGE;
        c.res    = ffra_pkg::RES_ZERO;
        c.status = ffra_pkg::ST_OK;
        state_d  = ffra_pkg::S_DONE;
      end
      ffra_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          c.publish = 1'b1;
          state_d   = ffra_pkg::S_IDLE;
        end
      end
      default: state_d = ffra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    if (c.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign cmd_o       = c;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/first_fit_region_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// Address-ordered region table with first-fit/fixed allocation, free,
// lookup and coalescing; one result word per command word.
//
//   port group   dir   handshake             payload
//   in           in    in_valid/in_ready     in_data_i  (ffra_pkg::in_t)
//   out          out   out_valid/out_ready   out_data_o (ffra_pkg::out_t)
//   cfg          in    APB psel/penable      paddr/pwdata/prdata (64 bit)
//
// One command at a time. A table scan reads each entry visited in S_RD and
// checks it in S_CHK (one memory read port, registered read data); a split
// shifts the tail of the table one entry at a time through S_SH_RD and
// S_SH_WR, then up to 3 writes. After reset the table is loaded from the
// configuration registers in S_BOOT before the first word is taken.
// A stalled result word sits in the output register; the next command is
// taken meanwhile and waits only for its own handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_region_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ffra_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ffra_pkg::out_t                out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ffra_pkg::CFG_AW-1:0]   paddr,
  input  logic [ffra_pkg::CFG_DW-1:0]   pwdata,
  output logic [ffra_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  logic [ffra_pkg::ADDR_W-1:0]  space_base_q;
  logic [ffra_pkg::BYTES_W-1:0] space_size_q;
  ffra_pkg::dp_cmd_t            dp_cmd;
  ffra_pkg::dp_stat_t           dp_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_base_q <= '0;
      space_size_q <= ffra_pkg::BYTES_W'(1) << ffra_pkg::ADDR_W;
    end else if (psel && penable && pwrite) begin
      if (paddr[3]) begin
        space_size_q <= pwdata[ffra_pkg::BYTES_W-1:0];
      end else begin
        space_base_q <= pwdata[ffra_pkg::ADDR_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[3] ? ffra_pkg::CFG_DW'(space_size_q) : ffra_pkg::CFG_DW'(space_base_q);

  ffra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  ffra_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat),
    .in_data_i    (in_data_i),
    .space_base_i (space_base_q),
    .space_size_i (space_size_q),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/ffra_checker.sv
// ----------------------------------------------------------------------------
// ffra_checker
// Port-level checks of the region allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_region_allocator_core_assert.svh"

module ffra_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input ffra_pkg::out_t out_data_o
);

  `FFRA_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word dropped or changed while stalled")
  `FFRA_ASSERT_IMP(a_err_zero, out_valid_o && (out_data_o.status != ffra_pkg::ST_OK), (out_data_o.region_base == '0) && (out_data_o.region_size == '0) && !out_data_o.region_is_free, "error result carries a region")
  `FFRA_ASSERT_IMP(a_count_max, out_valid_o, out_data_o.region_count <= ffra_pkg::MAX_REGIONS, "region count above table depth")
  `FFRA_ASSERT_NXT(a_one_cmd, in_valid_i && in_ready_o, !in_ready_o, "second command taken while one is in progress")

endmodule

bind first_fit_region_allocator_core ffra_checker u_ffra_checker (.*);

`default_nettype wire
